// ===== hdl/morph_target_blend_and_bound_defines.svh =====
// assertion macros shared by the morph blend checker
// no dependencies; included by files that hold concurrent assertions
`ifndef MORPH_TARGET_BLEND_AND_BOUND_DEFINES_SVH
`define MORPH_TARGET_BLEND_AND_BOUND_DEFINES_SVH

// same-cycle implication
`define MTB_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("mtb check failed");

// next-cycle implication
`define MTB_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("mtb check failed");

`endif

// ===== hdl/mtb_pkg.sv =====
// shared types and constants for the morph blend and bound block
// no dependencies; imported by every module of the block
package mtb_pkg;

   localparam int COORD_BITS_DEF  = 24;
   localparam int WEIGHT_FRAC_DEF = 12;
   localparam int WEIGHT_BITS     = 16;
   localparam int QUEUE_DEPTH     = 8;
   localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      KIND_POSITION = 1'b0,
      KIND_BOX      = 1'b1
   } kind_type;

   typedef struct packed {
      logic load;
      logic a_valid;
      logic a_is_base;
      logic a_vertex_end;
      logic b_valid;
      logic box_empty;
   } lane_ctrl_type;

   typedef struct packed {
      logic sum_clamp;
      logic reach_clamp;
      logic fold_clamp;
   } lane_stat_type;

   typedef struct packed {
      logic wr_en;
      logic pos_sat;
      logic has_box;
      logic box_sat;
   } q_write_type;

endpackage

// ===== hdl/morph_target_blend_and_bound.sv =====
// morph target blend and bound: top level with three coordinate lanes
// depends on mtb_pkg, mtb_lane, mtb_merge and mtb_rsp_queue
//
// req channel: one morph row per transfer. a base row (tuser bit 0) sets the
// vertex position; an offset row adds offset times weight (Q3.12, rounded)
// and widens the vertex reach. tlast marks the last row of a vertex, tuser
// bit 1 the last vertex of the mesh.
// rsp channel: a position result (tuser 0) per vertex end, followed by the
// mesh box (tuser 1) when that vertex closes the mesh; tlast marks the last
// result caused by one row. coordinates are Q15.8 and saturate.
// throughput: one row per cycle while req_tready is high; a mesh end row puts
// two results on rsp, sent as two transfers.
// a result passes the product register, the lane state update and the box fold
// into the result queue before it is presented on rsp.
// the rsp side is decoupled by an 8-entry queue; req_tready drops only when
// the queue plus rows in flight would fill it, so a stalled receiver holds
// results in place and then stops input.
// reset clears the vertex state and empties the mesh box; no clearing pass.
module morph_target_blend_and_bound
   import mtb_pkg::*;
#(
   parameter int COORD_BITS       = COORD_BITS_DEF,
   parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_DEF,
   localparam int IN_DATA_W  = ((3 * COORD_BITS + WEIGHT_BITS + 7) / 8) * 8,
   localparam int OUT_DATA_W = ((6 * COORD_BITS + 1 + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [IN_DATA_W-1:0]  req_tdata,   // coord_x, coord_y, coord_z, blend_weight
   input  logic [1:0]            req_tuser,   // is_base, mesh_end
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [OUT_DATA_W-1:0] rsp_tdata,   // lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, saturated
   output logic                  rsp_tuser,   // kind
   output logic                  rsp_tlast
);

   logic [2:0][COORD_BITS-1:0]  coord;
   logic [WEIGHT_BITS-1:0]      weight;
   lane_ctrl_type               lane_ctrl;
   lane_stat_type [2:0]         lane_stat;
   q_write_type                 q_write;
   logic [QCNT_W-1:0]           queue_count;
   logic [2:0][COORD_BITS-1:0]  pos_lane, lo_lane, hi_lane;
   logic [2:0][COORD_BITS-1:0]  rsp_lo, rsp_hi;
   logic                        rsp_sat;
   kind_type                    rsp_kind;

   assign coord  = req_tdata[3*COORD_BITS-1:0];
   assign weight = req_tdata[3*COORD_BITS+WEIGHT_BITS-1:3*COORD_BITS];

   mtb_merge u_merge (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_is_base    (req_tuser[0]),
      .req_vertex_end (req_tlast),
      .req_mesh_end   (req_tuser[1]),
      .queue_count    (queue_count),
      .lane_stat      (lane_stat),
      .req_tready     (req_tready),
      .lane_ctrl      (lane_ctrl),
      .q_write        (q_write)
   );

   for (genvar c = 0; c < 3; c++) begin : g_lane
      mtb_lane #(
         .COORD_BITS       (COORD_BITS),
         .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
      ) u_lane (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (lane_ctrl),
         .coord_in   ($signed(coord[c])),
         .weight_in  ($signed(weight)),
         .pos_out    (pos_lane[c]),
         .box_lo_out (lo_lane[c]),
         .box_hi_out (hi_lane[c]),
         .stat       (lane_stat[c])
      );
   end

   mtb_rsp_queue #(
      .COORD_BITS (COORD_BITS)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .q_write     (q_write),
      .wr_pos      (pos_lane),
      .wr_lo       (lo_lane),
      .wr_hi       (hi_lane),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_kind    (rsp_kind),
      .rsp_lo      (rsp_lo),
      .rsp_hi      (rsp_hi),
      .rsp_sat     (rsp_sat),
      .rsp_last    (rsp_tlast),
      .queue_count (queue_count)
   );

   assign rsp_tdata = OUT_DATA_W'({rsp_sat, rsp_hi, rsp_lo});
   assign rsp_tuser = rsp_kind;

endmodule

// ===== hdl/mtb_lane.sv =====
// one coordinate lane: weighted product, running position, reach and box fold
// depends on mtb_pkg
module mtb_lane
   import mtb_pkg::*;
#(
   parameter int COORD_BITS       = COORD_BITS_DEF,
   parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lane_ctrl_type                 ctrl,
   input  logic signed [COORD_BITS-1:0]  coord_in,
   input  logic signed [WEIGHT_BITS-1:0] weight_in,
   output logic signed [COORD_BITS-1:0]  pos_out,
   output logic signed [COORD_BITS-1:0]  box_lo_out,
   output logic signed [COORD_BITS-1:0]  box_hi_out,
   output lane_stat_type                 stat
);

   localparam int PROD_W  = COORD_BITS + WEIGHT_BITS;
   localparam int SCALE_W = PROD_W - WEIGHT_FRAC_BITS;
   localparam int SUM_W   = SCALE_W + 1;
   localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
   localparam logic signed [PROD_W-1:0] ROUND_K = PROD_W'(1) << (WEIGHT_FRAC_BITS - 1);

   // returns {clamped, value}
   function automatic logic [COORD_BITS:0] clamp_to_coord(input logic signed [SUM_W-1:0] v);
      logic [SUM_W-COORD_BITS:0] upper;
      upper = v[SUM_W-1:COORD_BITS-1];
      if ((&upper) || !(|upper)) begin
         clamp_to_coord = {1'b0, v[COORD_BITS-1:0]};
      end else if (v[SUM_W-1]) begin
         clamp_to_coord = {1'b1, C_MIN};
      end else begin
         clamp_to_coord = {1'b1, C_MAX};
      end
   endfunction

   logic signed [PROD_W-1:0]     prod;
   logic signed [SCALE_W-1:0]    scale_a_ff;
   logic signed [COORD_BITS-1:0] coord_a_ff;

   logic signed [COORD_BITS-1:0] sum_ff, base_ff, rlo_ff, rhi_ff;
   logic signed [COORD_BITS-1:0] sum_in, base_in, rlo_in, rhi_in;
   logic [COORD_BITS:0]          sum_sat, rlo_sat, rhi_sat;

   logic signed [COORD_BITS-1:0] pos_b_ff, base_b_ff, rlo_b_ff, rhi_b_ff;
   logic signed [COORD_BITS-1:0] box_lo_ff, box_hi_ff, box_lo_in, box_hi_in;
   logic [COORD_BITS:0]          lo_fold, hi_fold;
   logic signed [COORD_BITS-1:0] lo_val, hi_val;
   logic                         sum_clamp, reach_clamp;

   // stage a: rounded product
   assign prod = PROD_W'(coord_in) * PROD_W'(weight_in) + ROUND_K;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         scale_a_ff <= $signed(prod[PROD_W-1:WEIGHT_FRAC_BITS]);
         coord_a_ff <= coord_in;
      end
   end

   // running position and reach
   assign sum_sat = clamp_to_coord(SUM_W'(sum_ff) + SUM_W'(scale_a_ff));
   assign rlo_sat = clamp_to_coord(SUM_W'(rlo_ff) + SUM_W'(coord_a_ff));
   assign rhi_sat = clamp_to_coord(SUM_W'(rhi_ff) + SUM_W'(coord_a_ff));

   always_comb begin
      sum_in      = sum_ff;
      base_in     = base_ff;
      rlo_in      = rlo_ff;
      rhi_in      = rhi_ff;
      sum_clamp   = 1'b0;
      reach_clamp = 1'b0;
      if (ctrl.a_is_base) begin
         sum_in  = coord_a_ff;
         base_in = coord_a_ff;
         rlo_in  = '0;
         rhi_in  = '0;
      end else begin
         sum_in    = sum_sat[COORD_BITS-1:0];
         sum_clamp = sum_sat[COORD_BITS];
         if (!coord_a_ff[COORD_BITS-1] && (|coord_a_ff)) begin
            rhi_in      = rhi_sat[COORD_BITS-1:0];
            reach_clamp = rhi_sat[COORD_BITS];
         end else begin
            rlo_in      = rlo_sat[COORD_BITS-1:0];
            reach_clamp = rlo_sat[COORD_BITS];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         base_ff <= '0;
         rlo_ff  <= '0;
         rhi_ff  <= '0;
      end else if (ctrl.a_valid) begin
         if (ctrl.a_vertex_end) begin
            sum_ff  <= '0;
            base_ff <= '0;
            rlo_ff  <= '0;
            rhi_ff  <= '0;
         end else begin
            sum_ff  <= sum_in;
            base_ff <= base_in;
            rlo_ff  <= rlo_in;
            rhi_ff  <= rhi_in;
         end
      end
   end

   // stage b: fold vertex extent into the mesh box
   assign lo_fold = clamp_to_coord(SUM_W'(base_b_ff) + SUM_W'(rlo_b_ff));
   assign hi_fold = clamp_to_coord(SUM_W'(base_b_ff) + SUM_W'(rhi_b_ff));
   assign lo_val  = lo_fold[COORD_BITS-1:0];
   assign hi_val  = hi_fold[COORD_BITS-1:0];

   assign box_lo_in = (ctrl.box_empty || (lo_val < box_lo_ff)) ? lo_val : box_lo_ff;
   assign box_hi_in = (ctrl.box_empty || (hi_val > box_hi_ff)) ? hi_val : box_hi_ff;

   always_ff @(posedge clock) begin
      if (ctrl.a_valid && ctrl.a_vertex_end) begin
         pos_b_ff  <= sum_in;
         base_b_ff <= base_in;
         rlo_b_ff  <= rlo_in;
         rhi_b_ff  <= rhi_in;
      end
      if (ctrl.b_valid) begin
         box_lo_ff <= box_lo_in;
         box_hi_ff <= box_hi_in;
      end
   end

   assign pos_out          = pos_b_ff;
   assign box_lo_out       = box_lo_in;
   assign box_hi_out       = box_hi_in;
   assign stat.sum_clamp   = sum_clamp;
   assign stat.reach_clamp = reach_clamp;
   assign stat.fold_clamp  = lo_fold[COORD_BITS] | hi_fold[COORD_BITS];

endmodule

// ===== hdl/mtb_merge.sv =====
// control pipeline and merge of lane clamp flags into vertex and mesh flags
// depends on mtb_pkg
module mtb_merge
   import mtb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_is_base,
   input  logic                  req_vertex_end,
   input  logic                  req_mesh_end,
   input  logic [QCNT_W-1:0]     queue_count,
   input  lane_stat_type [2:0]   lane_stat,
   output logic                  req_tready,
   output lane_ctrl_type         lane_ctrl,
   output q_write_type           q_write
);

   logic [QCNT_W:0] pending;
   logic            load;
   logic            a_valid_ff, a_base_ff, a_vend_ff, a_mend_ff;
   logic            b_valid_ff, b_mend_ff, b_pos_sat_ff, b_reach_ff;
   logic            clamp_seen_ff, reach_clamped_ff, box_clamped_ff, box_empty_ff;
   logic            any_sum, any_reach, any_fold;
   logic            clamp_seen_in, reach_clamped_in, box_sat_in;

   // room for every result already on its way plus one more pair
   assign pending = (QCNT_W+1)'(queue_count) + (QCNT_W+1)'(a_valid_ff)
                  + (QCNT_W+1)'(b_valid_ff);
   assign req_tready = pending < (QCNT_W+1)'(QUEUE_DEPTH);
   assign load       = req_tvalid && req_tready;

   assign any_sum   = lane_stat[0].sum_clamp | lane_stat[1].sum_clamp | lane_stat[2].sum_clamp;
   assign any_reach = lane_stat[0].reach_clamp | lane_stat[1].reach_clamp
                    | lane_stat[2].reach_clamp;
   assign any_fold  = lane_stat[0].fold_clamp | lane_stat[1].fold_clamp
                    | lane_stat[2].fold_clamp;

   assign clamp_seen_in    = (a_base_ff ? 1'b0 : clamp_seen_ff) | any_sum;
   assign reach_clamped_in = (a_base_ff ? 1'b0 : reach_clamped_ff) | any_reach;
   assign box_sat_in       = box_clamped_ff | b_reach_ff | any_fold;

   always_ff @(posedge clock) begin
      if (load) begin
         a_base_ff <= req_is_base;
         a_vend_ff <= req_vertex_end;
         a_mend_ff <= req_mesh_end;
      end
      if (a_valid_ff && a_vend_ff) begin
         b_mend_ff    <= a_mend_ff;
         b_pos_sat_ff <= clamp_seen_in;
         b_reach_ff   <= reach_clamped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff       <= 1'b0;
         b_valid_ff       <= 1'b0;
         clamp_seen_ff    <= 1'b0;
         reach_clamped_ff <= 1'b0;
         box_clamped_ff   <= 1'b0;
         box_empty_ff     <= 1'b1;
      end else begin
         a_valid_ff <= load;
         b_valid_ff <= a_valid_ff && a_vend_ff;
         if (a_valid_ff) begin
            if (a_vend_ff) begin
               clamp_seen_ff    <= 1'b0;
               reach_clamped_ff <= 1'b0;
            end else begin
               clamp_seen_ff    <= clamp_seen_in;
               reach_clamped_ff <= reach_clamped_in;
            end
         end
         if (b_valid_ff) begin
            box_clamped_ff <= b_mend_ff ? 1'b0 : box_sat_in;
            box_empty_ff   <= b_mend_ff;
         end
      end
   end

   assign lane_ctrl.load         = load;
   assign lane_ctrl.a_valid      = a_valid_ff;
   assign lane_ctrl.a_is_base    = a_base_ff;
   assign lane_ctrl.a_vertex_end = a_vend_ff;
   assign lane_ctrl.b_valid      = b_valid_ff;
   assign lane_ctrl.box_empty    = box_empty_ff;

   assign q_write.wr_en   = b_valid_ff;
   assign q_write.pos_sat = b_pos_sat_ff;
   assign q_write.has_box = b_mend_ff;
   assign q_write.box_sat = box_sat_in;

endmodule

// ===== hdl/mtb_rsp_queue.sv =====
// result queue: one entry per vertex holds the position and an optional box,
// sent as one or two transfers; depends on mtb_pkg
module mtb_rsp_queue
   import mtb_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  q_write_type                 q_write,
   input  logic [2:0][COORD_BITS-1:0]  wr_pos,
   input  logic [2:0][COORD_BITS-1:0]  wr_lo,
   input  logic [2:0][COORD_BITS-1:0]  wr_hi,
   input  logic                        rsp_tready,
   output logic                        rsp_tvalid,
   output kind_type                    rsp_kind,
   output logic [2:0][COORD_BITS-1:0]  rsp_lo,
   output logic [2:0][COORD_BITS-1:0]  rsp_hi,
   output logic                        rsp_sat,
   output logic                        rsp_last,
   output logic [QCNT_W-1:0]           queue_count
);

   localparam int ENTRY_W = 9 * COORD_BITS + 3;

   logic [ENTRY_W-1:0]         entry_ff [QUEUE_DEPTH];
   logic [ENTRY_W-1:0]         entry_in, head;
   logic [QPTR_W-1:0]          wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]          count_ff;
   kind_type                   kind_ff;
   logic [2:0][COORD_BITS-1:0] head_pos, head_lo, head_hi;
   logic                       head_pos_sat, head_has_box, head_box_sat;
   logic                       xfer, pop;

   assign entry_in = {q_write.box_sat, q_write.has_box, q_write.pos_sat, wr_hi, wr_lo, wr_pos};
   assign head     = entry_ff[rd_ptr_ff];

   assign head_pos     = head[3*COORD_BITS-1:0];
   assign head_lo      = head[6*COORD_BITS-1:3*COORD_BITS];
   assign head_hi      = head[9*COORD_BITS-1:6*COORD_BITS];
   assign head_pos_sat = head[9*COORD_BITS];
   assign head_has_box = head[9*COORD_BITS+1];
   assign head_box_sat = head[9*COORD_BITS+2];

   assign rsp_tvalid = count_ff != '0;
   assign xfer       = rsp_tvalid && rsp_tready;
   assign pop        = xfer && ((kind_ff == KIND_BOX) || !head_has_box);

   always_comb begin
      rsp_kind = kind_ff;
      if (kind_ff == KIND_BOX) begin
         rsp_lo   = head_lo;
         rsp_hi   = head_hi;
         rsp_sat  = head_box_sat;
         rsp_last = 1'b1;
      end else begin
         rsp_lo   = head_pos;
         rsp_hi   = '0;
         rsp_sat  = head_pos_sat;
         rsp_last = !head_has_box;
      end
   end

   always_ff @(posedge clock) begin
      if (q_write.wr_en) begin
         entry_ff[wr_ptr_ff] <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         kind_ff   <= KIND_POSITION;
      end else begin
         if (q_write.wr_en) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (q_write.wr_en && !pop) begin
            count_ff <= count_ff + QCNT_W'(1);
         end else if (!q_write.wr_en && pop) begin
            count_ff <= count_ff - QCNT_W'(1);
         end
         if (xfer) begin
            kind_ff <= pop ? KIND_POSITION : KIND_BOX;
         end
      end
   end

   assign queue_count = count_ff;

endmodule

// ===== hdl/mtb_checker.sv =====
// port-level checks on the result channel of the morph blend block
// depends on mtb_pkg and morph_target_blend_and_bound_defines.svh; bound to the top level
`include "morph_target_blend_and_bound_defines.svh"

module mtb_checker
   import mtb_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   localparam int OUT_DATA_W = ((6 * COORD_BITS + 1 + 7) / 8) * 8
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [OUT_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser,
   input logic                  rsp_tlast
);

   localparam int C = COORD_BITS;

   logic pos_open, box_ordered;

   // position transfer that still owes its box
   assign pos_open = rsp_tvalid && rsp_tready && !rsp_tuser && !rsp_tlast;

   assign box_ordered = ($signed(rsp_tdata[C-1:0]) <= $signed(rsp_tdata[4*C-1:3*C]))
                     && ($signed(rsp_tdata[2*C-1:C]) <= $signed(rsp_tdata[5*C-1:4*C]))
                     && ($signed(rsp_tdata[3*C-1:2*C]) <= $signed(rsp_tdata[6*C-1:5*C]));

   `MTB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)

   `MTB_ASSERT_NOW(a_box_is_last, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast)

   `MTB_ASSERT_NEXT(a_box_follows, clock, reset, pos_open, rsp_tvalid && rsp_tuser)

   `MTB_ASSERT_NOW(a_box_ordered, clock, reset, rsp_tvalid && rsp_tuser, box_ordered)

endmodule

bind morph_target_blend_and_bound mtb_checker #(
   .COORD_BITS (COORD_BITS)
) u_mtb_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ===== tb/tb.sv =====
// testbench for morph_target_blend_and_bound: streams morph rows, predicts positions and mesh boxes
// depends on mtb_pkg and the morph_target_blend_and_bound top level
`timescale 1ns / 100ps

module tb;
   import mtb_pkg::*;

   localparam int CW        = COORD_BITS_DEF;
   localparam int WFRAC     = WEIGHT_FRAC_DEF;
   localparam int IN_W      = ((3 * CW + WEIGHT_BITS + 7) / 8) * 8;
   localparam int OUT_W     = ((6 * CW + 1 + 7) / 8) * 8;
   localparam longint C_MAX = (longint'(1) <<< (CW - 1)) - 1;
   localparam longint C_MIN = -C_MAX - 1;
   localparam int RANDOM_ROWS = 600;

   typedef struct packed {
      logic                   is_base;
      logic [2:0][CW-1:0]     crd;
      logic [WEIGHT_BITS-1:0] weight;
      logic                   vertex_end;
      logic                   mesh_end;
   } morph_row_type;

   typedef struct packed {
      kind_type           kind;
      logic [2:0][CW-1:0] lo;
      logic [2:0][CW-1:0] hi;
      logic               saturated;
      logic               run_last;
   } blend_result_type;

   class blend_bound_tracker_type;
      longint pos_sum[3], base_pos[3], reach_lo[3], reach_hi[3], box_lo[3], box_hi[3];
      bit box_empty, pos_clamped, reach_clamped, box_clamped;
      blend_result_type due_results[$];
      int failures;

      function new();
         clear_vertex();
         clear_box();
         failures = 0;
      endfunction

      function void clear_vertex();
         for (int c = 0; c < 3; c++) begin
            pos_sum[c] = 0;
            base_pos[c] = 0;
            reach_lo[c] = 0;
            reach_hi[c] = 0;
         end
         pos_clamped = 0;
         reach_clamped = 0;
      endfunction

      function void clear_box();
         for (int c = 0; c < 3; c++) begin
            box_lo[c] = 0;
            box_hi[c] = 0;
         end
         box_empty = 1;
         box_clamped = 0;
      endfunction

      function longint clamp_coord(longint v, inout bit flag);
         if (v > C_MAX) begin
            flag = 1;
            return C_MAX;
         end
         if (v < C_MIN) begin
            flag = 1;
            return C_MIN;
         end
         return v;
      endfunction

      function void note_row(morph_row_type r);
         longint crd[3];
         longint w, prod, lo, hi;
         blend_result_type res;
         w = $signed(r.weight);
         for (int c = 0; c < 3; c++) crd[c] = $signed(r.crd[c]);
         if (r.is_base) begin
            clear_vertex();
            for (int c = 0; c < 3; c++) begin
               pos_sum[c] = crd[c];
               base_pos[c] = crd[c];
            end
         end else begin
            for (int c = 0; c < 3; c++) begin
               // round half up with a floor shift
               prod = (crd[c] * w + (longint'(1) <<< (WFRAC - 1))) >>> WFRAC;
               pos_sum[c] = clamp_coord(pos_sum[c] + prod, pos_clamped);
               if (crd[c] > 0) reach_hi[c] = clamp_coord(reach_hi[c] + crd[c], reach_clamped);
               else reach_lo[c] = clamp_coord(reach_lo[c] + crd[c], reach_clamped);
            end
         end
         if (r.vertex_end) begin
            res.kind = KIND_POSITION;
            for (int c = 0; c < 3; c++) begin
               res.lo[c] = pos_sum[c][CW-1:0];
               res.hi[c] = '0;
            end
            res.saturated = pos_clamped;
            res.run_last = !r.mesh_end;
            due_results = {due_results, res};
            if (reach_clamped) box_clamped = 1;
            for (int c = 0; c < 3; c++) begin
               lo = clamp_coord(base_pos[c] + reach_lo[c], box_clamped);
               hi = clamp_coord(base_pos[c] + reach_hi[c], box_clamped);
               if (box_empty || lo < box_lo[c]) box_lo[c] = lo;
               if (box_empty || hi > box_hi[c]) box_hi[c] = hi;
            end
            box_empty = 0;
            clear_vertex();
            if (r.mesh_end) begin
               res.kind = KIND_BOX;
               for (int c = 0; c < 3; c++) begin
                  res.lo[c] = box_lo[c][CW-1:0];
                  res.hi[c] = box_hi[c][CW-1:0];
               end
               res.saturated = box_clamped;
               res.run_last = 1;
               due_results = {due_results, res};
               clear_box();
            end
         end
      endfunction

      function bit field_ok(string name, longint want, longint got);
         if (want != got)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         return want == got;
      endfunction

      function void check_result(blend_result_type act);
         blend_result_type want;
         bit ok;
         if (due_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, act);
            failures++;
            return;
         end
         want = due_results.pop_front();
         ok = field_ok("kind", want.kind, act.kind);
         ok &= field_ok("lo_x", want.lo[0], act.lo[0]);
         ok &= field_ok("lo_y", want.lo[1], act.lo[1]);
         ok &= field_ok("lo_z", want.lo[2], act.lo[2]);
         ok &= field_ok("hi_x", want.hi[0], act.hi[0]);
         ok &= field_ok("hi_y", want.hi[1], act.hi[1]);
         ok &= field_ok("hi_z", want.hi[2], act.hi[2]);
         ok &= field_ok("saturated", want.saturated, act.saturated);
         ok &= field_ok("run_last", want.run_last, act.run_last);
         if (!ok) failures++;
      endfunction

      function int pending();
         return due_results.size();
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [IN_W-1:0]  req_tdata;   // coord_x, coord_y, coord_z, blend_weight
   logic [1:0]       req_tuser;   // is_base, mesh_end
   logic             req_tlast;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [OUT_W-1:0] rsp_tdata;   // lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, saturated
   logic             rsp_tuser;   // kind
   logic             rsp_tlast;

   blend_bound_tracker_type tracker = new();
   int rows_sent = 0;
   int rsp_hold_cycles = 0;
   bit tx_burst = 0;
   bit tx_flood = 0;
   bit rx_burst = 0;

   morph_target_blend_and_bound dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic logic [CW-1:0] rand_coord();
      case ($urandom_range(0, 9))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2, 3, 4: return 24'($urandom_range(0, 8192)) - 24'd4096;
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic [WEIGHT_BITS-1:0] rand_weight();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'h7FFF;
         2: return 16'h8000;
         3: return 16'h1000;
         4: return 16'hF000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic morph_row_type rand_row(bit b, bit ve, bit me);
      morph_row_type r;
      r.is_base = b;
      for (int c = 0; c < 3; c++) r.crd[c] = rand_coord();
      r.weight = rand_weight();
      r.vertex_end = ve;
      r.mesh_end = me;
      return r;
   endfunction

   function automatic morph_row_type row_of(int b, int x, int y, int z, int w, int ve, int me);
      morph_row_type r;
      r.is_base = b[0];
      r.crd[0] = x[CW-1:0];
      r.crd[1] = y[CW-1:0];
      r.crd[2] = z[CW-1:0];
      r.weight = w[WEIGHT_BITS-1:0];
      r.vertex_end = ve[0];
      r.mesh_end = me[0];
      return r;
   endfunction

   task automatic send_row(input morph_row_type r);
      int gap;
      gap = (tx_burst || tx_flood) ? 0 : $urandom_range(0, 17);
      if ($urandom_range(0, 19) == 0) tx_burst = !tx_burst;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {r.weight, r.crd};
      req_tuser  <= {r.mesh_end, r.is_base};
      req_tlast  <= r.vertex_end;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.note_row(r);
      rows_sent++;
   endtask

   task automatic wait_results_drained();
      while (tracker.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // result receiver
   initial begin
      int gap;
      rsp_tready = 1'b0;
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end
         gap = rx_burst ? 0 : $urandom_range(0, 17);
         if ($urandom_range(0, 19) == 0) rx_burst = !rx_burst;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      blend_result_type act;
      if (!reset && rsp_tvalid && rsp_tready) begin
         act.kind = kind_type'(rsp_tuser);
         act.lo = rsp_tdata[3*CW-1:0];
         act.hi = rsp_tdata[6*CW-1:3*CW];
         act.saturated = rsp_tdata[6*CW];
         act.run_last = rsp_tlast;
         tracker.check_result(act);
      end
   end

   initial begin
      #3_000_000;
      $display("** morph_target_blend_and_bound: FAILED **");
      $finish;
   end

   initial begin
      bit has_base, mend, last, hold_done, pause_done;
      int n_ofs, flood_until;
      hold_done = 0;
      pause_done = 0;
      flood_until = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      req_tlast = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // vertex without a base row
      send_row(row_of(0, 100, -100, 0, 4096, 1, 0));
      // extremes and clamping toward the top
      send_row(row_of(1, 8388607, 8388607, 8388607, 0, 0, 0));
      send_row(row_of(0, 8388607, 8388607, 8388607, 32767, 1, 1));
      // clamping toward the bottom, mixed signs
      send_row(row_of(1, -8388608, -8388608, -8388608, 32767, 0, 0));
      send_row(row_of(0, -8388608, 8388607, 0, -32768, 0, 0));
      // base row mid-vertex restarts it
      send_row(row_of(1, 1193046, -1193046, 42, 0, 0, 0));
      // zero weight still widens the reach
      send_row(row_of(0, 5000, -5000, 1, 0, 1, 0));
      // mesh end without vertex end is ignored
      send_row(row_of(0, 256, 512, -768, 4096, 0, 1));
      send_row(row_of(0, -256, 0, 768, -4096, 1, 1));
      // single base row closing a mesh
      send_row(row_of(1, 77, -77, 0, -1, 1, 1));
      // rounding at half
      send_row(row_of(0, 1, -1, 3, 2048, 1, 0));
      send_row(row_of(0, -1, 1, -3, -2048, 1, 0));
      // largest product
      send_row(row_of(0, -8388608, -8388608, -8388608, -32768, 1, 1));
      // reach sums clamp
      send_row(row_of(1, 0, 0, 0, 0, 0, 0));
      send_row(row_of(0, 8388607, 8388607, -8388608, 32767, 0, 0));
      send_row(row_of(0, 8388607, 8388607, -8388608, 32767, 1, 1));
      send_row(row_of(1, -4096, 4096, 0, 0, 1, 1));

      rows_sent = 0;
      while (rows_sent < RANDOM_ROWS) begin
         if (rows_sent >= 200 && !hold_done) begin
            hold_done = 1;
            rsp_hold_cycles = 300;
            tx_flood = 1;
            flood_until = rows_sent + 40;
         end
         if (tx_flood && rows_sent >= flood_until) tx_flood = 0;
         if (rows_sent >= 400 && !pause_done) begin
            pause_done = 1;
            req_tvalid <= 1'b0;
            wait_results_drained();
         end
         if ($urandom_range(0, 9) == 0) begin
            send_row(rand_row(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1))));
         end else begin
            has_base = ($urandom_range(0, 9) != 0);
            n_ofs = $urandom_range(0, 3);
            if (!has_base && n_ofs == 0) n_ofs = 1;
            mend = ($urandom_range(0, 3) == 0);
            if (has_base)
               send_row(rand_row(1'b1, n_ofs == 0,
                                 (n_ofs == 0) ? mend : ($urandom_range(0, 7) == 0)));
            for (int k = 0; k < n_ofs; k++) begin
               last = (k == n_ofs - 1);
               send_row(rand_row(1'b0, last, last ? mend : ($urandom_range(0, 7) == 0)));
            end
         end
      end
      req_tvalid <= 1'b0;
      wait_results_drained();

      if (tracker.failures == 0)
         $display("** morph_target_blend_and_bound: PASSED **");
      else
         $display("** morph_target_blend_and_bound: FAILED **");
      $finish;
   end

endmodule
